FILE: rtl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants for the scaled cosine distance unit
// Holds the command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int DIMS_DEFAULT        = 64;
  localparam int VALUE_WIDTH_DEFAULT = 16;
  localparam int INDEX_WIDTH         = 6;
  localparam int SCALE_WIDTH         = 16;
  localparam int COST_WIDTH          = 16;
  localparam int ACC_WIDTH           = 64;
  localparam int ROOT_WIDTH          = 32;
  localparam logic [SCALE_WIDTH-1:0] SCALE_ONE = 16'd256;
  localparam logic [COST_WIDTH-1:0]  ONE_Q14   = 16'd16384;
  localparam logic                   MODE_LOAD = 1'b0;
  localparam logic                   MODE_DATA = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch an accepted word into the input stage
    logic mac;        // scale and accumulate the captured element
    logic acc_clear;  // clear the accumulators
    logic sqrt_start; // load both root units
    logic sqrt_step;  // advance both root units by one bit
    logic mul_start;  // form root product
    logic div_start;  // load the divider
    logic div_step;   // advance the divider by one quotient bit
    logic finish;     // form cost into the output register
  } scd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_data;
    logic is_last;
    logic zero_norm;
    logic sat;
    logic clearing;   // scale table refill after reset
  } scd_status_t;

endpackage

FILE: rtl/scd_datapath.sv
// ----------------------------------------------------------------------------
// scd_datapath: scale table, MAC stages, root and divide units
// Scales one element, accumulates dot and norms, then closes out the cosine.
// ----------------------------------------------------------------------------
module scd_datapath
  import scd_pkg::*;
#(
  parameter int DIMS        = DIMS_DEFAULT,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  scd_cmd_t                      cmd,
  output scd_status_t                   status,
  input  logic                          in_mode,
  input  logic [INDEX_WIDTH-1:0]        in_dim_index,
  input  logic signed [VALUE_WIDTH-1:0] in_query,
  input  logic signed [VALUE_WIDTH-1:0] in_cand,
  input  logic [SCALE_WIDTH-1:0]        in_scale,
  input  logic                          in_last,
  input  logic                          rst,
  output logic [COST_WIDTH-1:0]         cost,
  output logic                          zero_norm
);

  localparam int DW   = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int PW   = VALUE_WIDTH + SCALE_WIDTH + 1;
  localparam int NIDX = 2 ** INDEX_WIDTH;
  localparam int QW   = 2 * (PW - 8);

  // Index modulo DIMS for every possible input index
  function automatic logic [NIDX*DW-1:0] idx_map();
    logic [NIDX*DW-1:0] m;
    m = '0;
    for (int i = 0; i < NIDX; i++) m[i*DW +: DW] = DW'(i % DIMS);
    return m;
  endfunction

  localparam logic [NIDX*DW-1:0] IDX_MAP = idx_map();

  // Input stage
  logic                          mode;
  logic [DW-1:0]                 idx;
  logic signed [VALUE_WIDTH-1:0] qv;
  logic signed [VALUE_WIDTH-1:0] cv;
  logic [SCALE_WIDTH-1:0]        sv;
  logic                          last;
  logic [DW-1:0]                 idx_next;

  // Reduce the index modulo DIMS
  assign idx_next = IDX_MAP[in_dim_index*DW +: DW];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode <= in_mode;
      idx  <= idx_next;
      qv   <= in_query;
      cv   <= in_cand;
      sv   <= in_scale;
      last <= in_last;
    end
  end

  // Refill the scale table with 1.0 after reset, one entry per cycle
  logic [DW-1:0] clr_idx;
  logic          clr_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == DW'(DIMS - 1)) clr_busy <= 1'b0;
    end
  end

  assign status.clearing = clr_busy;

  // Scale table, read at capture so the factor is registered for the MAC
  logic [SCALE_WIDTH-1:0] table_mem [DIMS];
  logic [SCALE_WIDTH-1:0] scale_rd;

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      table_mem[clr_idx] <= SCALE_ONE;
    end else if (cmd.mac && mode == MODE_LOAD) begin
      table_mem[idx] <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      scale_rd <= table_mem[idx_next];
    end
  end

  // Scaled values, floor shift by 8
  logic signed [PW-1:0] qp, cp;
  assign qp = PW'(qv) * $signed({1'b0, scale_rd});
  assign cp = PW'(cv) * $signed({1'b0, scale_rd});

  // Register scaled values, then multiply the registered values
  logic signed [PW-9:0] qs_r, cs_r;
  logic                 mul_vld, mul_last;
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
    end else begin
      mul_vld <= cmd.mac && mode == MODE_DATA;
    end
    qs_r     <= (PW-8)'(qp >>> 8);
    cs_r     <= (PW-8)'(cp >>> 8);
    mul_last <= last;
  end

  logic signed [QW-1:0] dot_p, qq_p, cc_p;
  assign dot_p = qs_r * cs_r;
  assign qq_p  = qs_r * qs_r;
  assign cc_p  = cs_r * cs_r;

  logic [ACC_WIDTH-1:0] dot_acc, qq_acc, cc_acc;
  always_ff @(posedge clk) begin
    if (rst || cmd.acc_clear) begin
      dot_acc <= '0;
      qq_acc  <= '0;
      cc_acc  <= '0;
    end else if (mul_vld) begin
      dot_acc <= dot_acc + ACC_WIDTH'(dot_p);
      qq_acc  <= qq_acc  + ACC_WIDTH'(qq_p);
      cc_acc  <= cc_acc  + ACC_WIDTH'(cc_p);
    end
  end

  assign status.is_data   = mode == MODE_DATA;
  assign status.is_last   = mul_last;
  assign status.zero_norm = (qq_acc == '0) || (cc_acc == '0);

  // Integer square roots, one result bit per step
  logic [ACC_WIDTH-1:0]  rq_rem, rc_rem, rq_res, rc_res, rbit;
  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rq_rem <= qq_acc;
      rc_rem <= cc_acc;
      rq_res <= '0;
      rc_res <= '0;
      rbit   <= ACC_WIDTH'(1) << (ACC_WIDTH - 2);
    end else if (cmd.sqrt_step) begin
      if (rq_rem >= rq_res + rbit) begin
        rq_rem <= rq_rem - (rq_res + rbit);
        rq_res <= (rq_res >> 1) + rbit;
      end else begin
        rq_res <= rq_res >> 1;
      end
      if (rc_rem >= rc_res + rbit) begin
        rc_rem <= rc_rem - (rc_res + rbit);
        rc_res <= (rc_res >> 1) + rbit;
      end else begin
        rc_res <= rc_res >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  // Root product and dot magnitude
  logic [ACC_WIDTH-1:0] den, mag;
  logic                 neg;
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      den <= ROOT_WIDTH'(rq_res) * ROOT_WIDTH'(rc_res);
      neg <= dot_acc[ACC_WIDTH-1];
      mag <= dot_acc[ACC_WIDTH-1] ? ACC_WIDTH'(0) - dot_acc : dot_acc;
    end
  end

  // Restoring divider, one quotient bit per step
  logic [ACC_WIDTH-1:0] drem;
  logic [COST_WIDTH-1:0] quo;
  logic                  sat;
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      drem <= mag;
      quo  <= '0;
      sat  <= mag >= den;
    end else if (cmd.div_step) begin
      if (drem[ACC_WIDTH-1] || {drem[ACC_WIDTH-2:0], 1'b0} >= den) begin
        drem <= {drem[ACC_WIDTH-2:0], 1'b0} - den;
        quo  <= {quo[COST_WIDTH-2:0], 1'b1};
      end else begin
        drem <= {drem[ACC_WIDTH-2:0], 1'b0};
        quo  <= {quo[COST_WIDTH-2:0], 1'b0};
      end
    end
  end
  assign status.sat = sat;

  // Round, clamp and form cost
  logic [COST_WIDTH-1:0] m_rnd, m_q;
  assign m_rnd = (quo + 1'b1) >> 1;
  assign m_q   = (sat || m_rnd > ONE_Q14) ? ONE_Q14 : m_rnd;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (status.zero_norm) begin
        cost      <= ONE_Q14;
        zero_norm <= 1'b1;
      end else begin
        cost      <= neg ? ONE_Q14 + m_q : ONE_Q14 - m_q;
        zero_norm <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/scd_ctrl.sv
// ----------------------------------------------------------------------------
// scd_ctrl: sequencer for the scaled cosine distance unit
// Accepts words, waits out the MAC, runs root and divide on the last element.
// ----------------------------------------------------------------------------
module scd_ctrl
  import scd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output scd_cmd_t    cmd,
  input  scd_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_ACC, S_SQRT, S_DIV, S_DONE
  } state_t;

  state_t     state;
  logic [5:0] cnt;
  logic       accept;

  // Take a word when idle and the scale table is ready
  assign in_stall = (state != S_IDLE) || status.clearing;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd            = '0;
    cmd.capture    = accept;
    cmd.mac        = state == S_MAC;
    cmd.sqrt_start = state == S_SQRT && cnt == 6'd33;
    cmd.sqrt_step  = state == S_SQRT && cnt != 6'd33 && cnt != 6'd0;
    cmd.mul_start  = state == S_SQRT && cnt == 6'd0;
    cmd.div_start  = state == S_DIV && cnt == 6'd16;
    cmd.div_step   = state == S_DIV && cnt != 6'd16 && cnt != 6'd0;
    cmd.finish     = state == S_DONE && (!out_valid || !out_stall);
    cmd.acc_clear  = state == S_DONE && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) state <= S_MAC;
        end
        S_MAC: begin
          // Load words finish here; data words wait for accumulation
          state <= status.is_data ? S_ACC : S_IDLE;
        end
        S_ACC: begin
          if (!status.is_last) begin
            state <= S_IDLE;
          end else begin
            state <= S_SQRT;
            cnt   <= 6'd33;
          end
        end
        S_SQRT: begin
          if (cnt == 6'd0) begin
            state <= S_DIV;
            cnt   <= 6'd16;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_DIV: begin
          if (cnt == 6'd0) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (cmd.finish) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/scaled_cosine_distance_unit.sv
// ----------------------------------------------------------------------------
// scaled_cosine_distance_unit: cosine distance over scaled feature vectors
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry one dimension each. mode 0 writes scale_value into the
//   scale table at dim_index; mode 1 feeds one query/candidate element.
//   A data word with last set closes the vector and yields one output word:
//   cost (Q2.14, 16384 = 1.0) and zero_norm.
// Sequence:
//   A load word goes through capture and table write; a non-last data word
//   through capture, scale and accumulate. A last data word also runs root
//   load, 32 root steps, product, divider load, 15 divider steps and one
//   spare step before the result register raises out_valid.
//   One word is in flight at a time.
// Reset:
//   rst clears the accumulators and the handshake state; a clearing pass
//   then fills every scale table entry with 1.0 while in_stall is high.
// Stall:
//   The result waits in the output register while out_stall is high; load
//   and non-last data words still go in, and the next closing word waits in
//   place until that result has been taken.
// ----------------------------------------------------------------------------
module scaled_cosine_distance_unit
  import scd_pkg::*;
#(
  parameter int DIMS        = DIMS_DEFAULT,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [INDEX_WIDTH-1:0]        dim_index,
  input  logic signed [VALUE_WIDTH-1:0] query_value,
  input  logic signed [VALUE_WIDTH-1:0] candidate_value,
  input  logic [SCALE_WIDTH-1:0]        scale_value,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COST_WIDTH-1:0]         cost,
  output logic                          zero_norm
);

  scd_cmd_t    cmd;
  scd_status_t status;

  scd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  scd_datapath #(
    .DIMS        (DIMS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .status       (status),
    .in_mode      (mode),
    .in_dim_index (dim_index),
    .in_query     (query_value),
    .in_cand      (candidate_value),
    .in_scale     (scale_value),
    .in_last      (last),
    .rst          (rst),
    .cost         (cost),
    .zero_norm    (zero_norm)
  );

endmodule

FILE: bench/scaled_cosine_distance_unit_tb.sv
// ----------------------------------------------------------------------------
// scaled_cosine_distance_unit_tb: self-checking bench for the distance unit
// Drives load and data words with bursty valid and random output stall,
// predicts cost and zero_norm per vector and checks every output word.
// ----------------------------------------------------------------------------
module scaled_cosine_distance_unit_tb;
  import scd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NDIMS = 64;

  typedef struct {
    logic [COST_WIDTH-1:0] cost;
    logic                  zero_norm;
  } dist_word_t;

  // Scoreboard: holds the predictor state and the queue of expected words
  class distance_board;
    logic [SCALE_WIDTH-1:0] scale_tab[NDIMS];
    logic [ACC_WIDTH-1:0]   dot_sum, qq_sum, cc_sum;
    dist_word_t             pending[$];
    int                     errors;

    function new();
      for (int i = 0; i < NDIMS; i++) scale_tab[i] = SCALE_ONE;
      dot_sum = '0; qq_sum = '0; cc_sum = '0; errors = 0;
    endfunction

    function logic [63:0] root64(logic [63:0] x);
      logic [63:0] rem, res, b;
      rem = x; res = 0; b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
        if (rem >= res + b) begin
          rem = rem - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function logic [31:0] frac_q14(logic [63:0] mag, logic [63:0] den);
      logic [63:0] r;
      logic [31:0] q;
      logic        cy;
      if (mag >= den) return 32'(ONE_Q14);
      r = mag; q = 0;
      for (int i = 0; i < 15; i++) begin
        cy = r[63];
        r = r << 1;
        q = q << 1;
        if (cy || r >= den) begin
          r = r - den;
          q[0] = 1'b1;
        end
      end
      q = (q + 1) >> 1;
      return (q > 32'(ONE_Q14)) ? 32'(ONE_Q14) : q;
    endfunction

    // Note one accepted input word
    function void note_word(logic md, logic [5:0] idx, logic signed [15:0] qv,
                            logic signed [15:0] cv, logic [15:0] sv, logic lst);
      logic signed [63:0] qs, cs;
      logic [63:0]        mag;
      logic [31:0]        m;
      dist_word_t         w;
      if (md == MODE_LOAD) begin
        scale_tab[idx % NDIMS] = sv;
        return;
      end
      qs = (64'(qv) * $signed({48'd0, scale_tab[idx % NDIMS]})) >>> 8;
      cs = (64'(cv) * $signed({48'd0, scale_tab[idx % NDIMS]})) >>> 8;
      dot_sum += qs * cs;
      qq_sum  += qs * qs;
      cc_sum  += cs * cs;
      if (!lst) return;
      if (qq_sum == 0 || cc_sum == 0) begin
        w.cost = ONE_Q14; w.zero_norm = 1'b1;
      end else begin
        mag = dot_sum[63] ? -dot_sum : dot_sum;
        m = frac_q14(mag, root64(qq_sum) * root64(cc_sum));
        w.cost = dot_sum[63] ? ONE_Q14 + m[15:0] : ONE_Q14 - m[15:0];
        w.zero_norm = 1'b0;
      end
      pending.push_back(w);
      dot_sum = '0; qq_sum = '0; cc_sum = '0;
    endfunction

    // Check one accepted output word against the oldest expectation
    function void check_word(logic [15:0] c, logic z);
      dist_word_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word cost=%0d zero_norm=%0d", $time, c, z);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (c !== w.cost) begin
        $display("%0t: cost expected %0d actual %0d", $time, w.cost, c);
        errors++;
      end
      if (z !== w.zero_norm) begin
        $display("%0t: zero_norm expected %0d actual %0d", $time, w.zero_norm, z);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, mode = 1'b0, last = 1'b0, out_stall = 1'b0;
  logic [5:0] dim_index = '0;
  logic signed [15:0] query_value = '0, candidate_value = '0;
  logic [15:0] scale_value = '0;
  logic in_stall, out_valid, zero_norm;
  logic [15:0] cost;

  distance_board board = new();
  int  cycles = 0;
  bit  hold_out = 1'b0;
  int  vec_len = 3;
  int  vec_pos = 0;

  scaled_cosine_distance_unit dut (
    .clk, .rst, .in_valid, .in_stall, .mode, .dim_index, .query_value,
    .candidate_value, .scale_value, .last, .out_valid, .out_stall, .cost,
    .zero_norm
  );

  always #4 clk = ~clk;

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && in_valid && !in_stall)
      board.note_word(mode, dim_index, query_value, candidate_value, scale_value, last);
    if (!rst && out_valid && !out_stall) board.check_word(cost, zero_norm);
    if (cycles > 2000000) begin
      $display("scaled_cosine_distance_unit_tb: errors");
      $finish;
    end
  end

  // Stall the output on a pattern of its own, with quiet stretches
  initial begin
    int mode_len;
    @(negedge clk);
    forever begin
      mode_len = $urandom_range(10, 80);
      case ($urandom_range(0, 2))
        0: repeat (mode_len) begin
          out_stall <= hold_out; @(negedge clk);
        end
        default: repeat (mode_len) begin
          out_stall <= hold_out || ($urandom_range(0, 3) == 0); @(negedge clk);
        end
      endcase
    end
  end

  // Offer one word and hold it until accepted
  task automatic send_word(logic md, logic [5:0] idx, logic [15:0] qv,
                           logic [15:0] cv, logic [15:0] sv, logic lst);
    in_valid <= 1'b1; mode <= md; dim_index <= idx; query_value <= qv;
    candidate_value <= cv; scale_value <= sv; last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_bus(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, 1024));
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one random word, mostly well-formed vectors
  task automatic random_word;
    logic [15:0] sv;
    if ($urandom_range(0, 9) == 0) begin
      sv = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
      if ($urandom_range(0, 7) == 0) sv = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      send_word(MODE_LOAD, 6'($urandom), pick_value(), pick_value(), sv, 1'($urandom));
      return;
    end
    vec_pos++;
    send_word(MODE_DATA, 6'($urandom), pick_value(), pick_value(), 16'($urandom),
              vec_pos >= vec_len);
    if (vec_pos >= vec_len) begin
      vec_pos = 0;
      vec_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
    end
  endtask

  initial begin
    int burst;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero norm, extremes, ignored last on load, opposite vectors
    send_word(MODE_DATA, 6'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    send_word(MODE_DATA, 6'd1, 16'd256, 16'd0, 16'd0, 1'b1);
    send_word(MODE_DATA, 6'd2, 16'h7FFF, 16'h7FFF, 16'd0, 1'b1);
    send_word(MODE_DATA, 6'd3, 16'h8000, 16'h7FFF, 16'd0, 1'b1);
    send_word(MODE_DATA, 6'd4, 16'h8000, 16'h8000, 16'd0, 1'b0);
    send_word(MODE_DATA, 6'd5, 16'd300, 16'hFF00, 16'd0, 1'b1);
    send_word(MODE_LOAD, 6'd63, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1);
    send_word(MODE_LOAD, 6'd7, 16'd0, 16'd0, 16'h0000, 1'b0);
    send_word(MODE_DATA, 6'd63, 16'h7FFF, 16'h8000, 16'd0, 1'b0);
    send_word(MODE_DATA, 6'd63, 16'h8000, 16'h8000, 16'd0, 1'b1);
    send_word(MODE_DATA, 6'd7, 16'd500, 16'd500, 16'd0, 1'b1);
    send_word(MODE_DATA, 6'd63, 16'd1, 16'hFFFF, 16'd0, 1'b1);
    send_word(MODE_LOAD, 6'd10, 16'd0, 16'd0, 16'd1, 1'b0);
    send_word(MODE_DATA, 6'd10, 16'd3, 16'hFFFD, 16'd0, 1'b1);
    drain();

    // Long output hold while the sender keeps offering words
    hold_out = 1'b1;
    fork
      repeat (40) random_word();
      begin repeat (400) @(negedge clk); hold_out = 1'b0; end
    join
    drain();

    // Random bursts with gaps
    for (int n = 0; n < 1850; n += burst) begin
      burst = $urandom_range(1, 40);
      repeat (burst) random_word();
      if ($urandom_range(0, 2) != 0) pause_bus($urandom_range(1, 30));
    end
    send_word(MODE_DATA, 6'd0, 16'd100, 16'd100, 16'd0, 1'b1);
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("scaled_cosine_distance_unit_tb: clean");
    end else begin
      $display("scaled_cosine_distance_unit_tb: errors");
    end
    $finish;
  end
endmodule
